[src/wsts_pkg.sv]
// ----------------------------------------------------------------------------
// Work-stealing task scheduler package
// Shared widths, codes, controller states and the command bundle that runs
// from the controller to the datapath.
// ----------------------------------------------------------------------------
package wsts_pkg;

	// Fixed field widths of the ports
	localparam int TAG_W     = 16;
	localparam int WORKER_W  = 3;
	localparam int STATUS_W  = 3;
	localparam int QUSED_W   = 3;
	localparam int ACTIVE_W  = 4;
	localparam int PDATA_W   = 32;
	localparam int PADDR_W   = 3;

	// Default sizes of the queue set
	localparam int NUM_QUEUES_DEF  = 8;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TAG_BITS_DEF    = 16;

	// Reset value of the active worker count
	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

	// Register index (byte address divided by four)
	localparam logic [PADDR_W-3:0] REG_ACTIVE_WORKERS = 1'b0;

	// Request codes on the command field
	typedef enum logic {
		CMD_SUBMIT = 1'b0,
		CMD_FETCH  = 1'b1
	} command_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_SUBMITTED = 3'd0,
		ST_FULL      = 3'd1,
		ST_OWN       = 3'd2,
		ST_STOLEN    = 3'd3,
		ST_NONE      = 3'd4
	} status_t;

	// Queue operation decided when the transaction is taken
	typedef enum logic [1:0] {
		OP_SUBMIT = 2'd0,
		OP_OWN    = 2'd1,
		OP_STEAL  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE    = 2'd0,
		S_ACCESS  = 2'd1,
		S_DELIVER = 2'd2
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;   // capture the request and its queue choice
		logic access;   // update queue pointers and drive the task memory
		logic deliver;  // load the output register
	} cmd_t;

endpackage

[src/wsts_ctrl.sv]
// ----------------------------------------------------------------------------
// Work-stealing task scheduler controller
// Sequences each transaction through queue access and delivery and owns the
// handshake of both channels.
// ----------------------------------------------------------------------------
module wsts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output wsts_pkg::cmd_t  cmd
);

	wsts_pkg::state_t state_q;
	wsts_pkg::state_t state_nxt;
	logic             out_valid_q;
	logic             out_free;
	logic             accept;

	// Output register can take a new result this cycle
	assign out_free = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			wsts_pkg::S_IDLE: begin
				if (accept) begin
					state_nxt = wsts_pkg::S_ACCESS;
				end
			end
			wsts_pkg::S_ACCESS: begin
				state_nxt = wsts_pkg::S_DELIVER;
			end
			wsts_pkg::S_DELIVER: begin
				if (out_free) begin
					state_nxt = accept ? wsts_pkg::S_ACCESS : wsts_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = wsts_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs: take a new request while idle or while the last result leaves
	always_comb begin
		in_ready    = 1'b0;
		cmd.access  = 1'b0;
		cmd.deliver = 1'b0;
		case (state_q)
			wsts_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			wsts_pkg::S_ACCESS: begin
				cmd.access = 1'b1;
			end
			wsts_pkg::S_DELIVER: begin
				in_ready    = out_free;
				cmd.deliver = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		cmd.accept = in_valid && in_ready;
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wsts_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.deliver) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

[src/wsts_dp.sv]
// ----------------------------------------------------------------------------
// Work-stealing task scheduler datapath
// Queue choice, per-queue front and count registers, the task memory and the
// result register.
// ----------------------------------------------------------------------------
module wsts_dp #(
	parameter int NUM_QUEUES  = wsts_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = wsts_pkg::QUEUE_DEPTH_DEF,
	parameter int TAG_BITS    = wsts_pkg::TAG_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wsts_pkg::cmd_t                cmd,
	input  logic [wsts_pkg::ACTIVE_W-1:0] active_workers,
	input  logic                          command,
	input  logic [wsts_pkg::TAG_W-1:0]    task_tag,
	input  logic [wsts_pkg::WORKER_W-1:0] worker,
	output logic [wsts_pkg::STATUS_W-1:0] status,
	output logic [wsts_pkg::TAG_W-1:0]    out_tag,
	output logic [wsts_pkg::QUSED_W-1:0]  queue_used
);

	localparam int QW    = $clog2(NUM_QUEUES);
	localparam int DW    = $clog2(QUEUE_DEPTH);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int SumW  = DW + 1;
	localparam int ActW  = $clog2(NUM_QUEUES + 1);
	localparam int SB    = (TAG_BITS < wsts_pkg::TAG_W) ? TAG_BITS : wsts_pkg::TAG_W;
	localparam int AddrW = QW + DW;
	localparam int MemD  = NUM_QUEUES << DW;

	// Queue state
	logic [DW-1:0]       front_q [NUM_QUEUES];
	logic [CW-1:0]       count_q [NUM_QUEUES];
	logic [QW-1:0]       rr_q;

	// Task memory
	logic [SB-1:0]       mem [MemD];
	logic [SB-1:0]       rdata_q;

	// Request captured at accept
	wsts_pkg::op_t       op_s1;
	logic [QW-1:0]       q_s1;
	logic [SB-1:0]       tag_s1;

	// Result of the queue access
	wsts_pkg::status_t   status_s2;
	logic [QW-1:0]       qused_s2;
	logic                has_tag_s2;

	// Output register
	wsts_pkg::status_t   status_q;
	logic [wsts_pkg::TAG_W-1:0]   out_tag_q;
	logic [wsts_pkg::QUSED_W-1:0] queue_used_q;

	logic [ActW-1:0]     act;
	logic [QW-1:0]       sub_q;
	logic [QW-1:0]       rr_next;
	logic [QW-1:0]       steal_q;
	logic                steal_ok;
	logic                own_hit;
	logic                own_ok;
	wsts_pkg::op_t       op_pick;
	logic [QW-1:0]       q_pick;

	logic [DW-1:0]       front_sel;
	logic [CW-1:0]       count_sel;
	logic                full;
	logic [DW-1:0]       front_dec;
	logic [DW-1:0]       front_inc;
	logic [SumW-1:0]     back_sum;
	logic [DW-1:0]       back_idx;
	logic [DW-1:0]       mem_idx;
	logic [AddrW-1:0]    mem_addr;
	logic                mem_we;
	logic                mem_re;

	// Clamp the active count to 1 .. NUM_QUEUES
	always_comb begin
		if (active_workers == '0) begin
			act = ActW'(1);
		end else if (int'(active_workers) > NUM_QUEUES) begin
			act = ActW'(NUM_QUEUES);
		end else begin
			act = ActW'(active_workers);
		end
	end

	// Round-robin submit target; a stale pointer falls back to queue 0
	always_comb begin
		sub_q   = (int'(rr_q) < int'(act)) ? rr_q : '0;
		rr_next = (int'(sub_q) + 1 >= int'(act)) ? '0 : sub_q + QW'(1);
	end

	// Own queue check and lowest-numbered steal victim
	always_comb begin
		own_hit  = 1'b0;
		steal_ok = 1'b0;
		steal_q  = '0;
		for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
			if (count_q[i] != '0 && i == int'(worker)) begin
				own_hit = 1'b1;
			end
			if (count_q[i] != '0 && i < int'(act) && i != int'(worker)) begin
				steal_ok = 1'b1;
				steal_q  = QW'(i);
			end
		end
		own_ok = own_hit && (int'(worker) < int'(act));
	end

	// Choose the operation and its queue
	always_comb begin
		if (command == wsts_pkg::CMD_SUBMIT) begin
			op_pick = wsts_pkg::OP_SUBMIT;
			q_pick  = sub_q;
		end else if (own_ok) begin
			op_pick = wsts_pkg::OP_OWN;
			q_pick  = QW'(worker);
		end else if (steal_ok) begin
			op_pick = wsts_pkg::OP_STEAL;
			q_pick  = steal_q;
		end else begin
			op_pick = wsts_pkg::OP_NONE;
			q_pick  = '0;
		end
	end

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_s1  <= op_pick;
			q_s1   <= q_pick;
			tag_s1 <= task_tag[SB-1:0];
		end
	end

	// Pointer arithmetic for the chosen queue
	always_comb begin
		front_sel = front_q[q_s1];
		count_sel = count_q[q_s1];
		full      = (count_sel == CW'(QUEUE_DEPTH));
		front_dec = (front_sel == '0) ? DW'(QUEUE_DEPTH - 1) : front_sel - DW'(1);
		front_inc = (front_sel == DW'(QUEUE_DEPTH - 1)) ? '0 : front_sel + DW'(1);
		back_sum  = SumW'(front_sel) + SumW'(count_sel) - SumW'(1);
		back_idx  = (back_sum >= SumW'(QUEUE_DEPTH)) ?
			DW'(back_sum - SumW'(QUEUE_DEPTH)) : DW'(back_sum);
		case (op_s1)
			wsts_pkg::OP_SUBMIT: mem_idx = front_dec;
			wsts_pkg::OP_STEAL:  mem_idx = back_idx;
			default:             mem_idx = front_sel;
		endcase
		mem_addr = {q_s1, mem_idx};
		mem_we   = cmd.access && (op_s1 == wsts_pkg::OP_SUBMIT) && !full;
		mem_re   = cmd.access &&
			((op_s1 == wsts_pkg::OP_OWN) || (op_s1 == wsts_pkg::OP_STEAL));
	end

	// Task memory: one write or one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= tag_s1;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// Advance queue pointers and the round-robin pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				front_q[i] <= '0;
				count_q[i] <= '0;
			end
			rr_q <= '0;
		end else begin
			if (cmd.accept && command == wsts_pkg::CMD_SUBMIT) begin
				rr_q <= rr_next;
			end
			if (cmd.access) begin
				case (op_s1)
					wsts_pkg::OP_SUBMIT: begin
						if (!full) begin
							front_q[q_s1] <= front_dec;
							count_q[q_s1] <= count_sel + CW'(1);
						end
					end
					wsts_pkg::OP_OWN: begin
						front_q[q_s1] <= front_inc;
						count_q[q_s1] <= count_sel - CW'(1);
					end
					wsts_pkg::OP_STEAL: begin
						count_q[q_s1] <= count_sel - CW'(1);
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Hold the access outcome until delivery
	always_ff @(posedge clk) begin
		if (cmd.access) begin
			case (op_s1)
				wsts_pkg::OP_SUBMIT: begin
					status_s2  <= full ? wsts_pkg::ST_FULL : wsts_pkg::ST_SUBMITTED;
					qused_s2   <= q_s1;
					has_tag_s2 <= 1'b0;
				end
				wsts_pkg::OP_OWN: begin
					status_s2  <= wsts_pkg::ST_OWN;
					qused_s2   <= q_s1;
					has_tag_s2 <= 1'b1;
				end
				wsts_pkg::OP_STEAL: begin
					status_s2  <= wsts_pkg::ST_STOLEN;
					qused_s2   <= q_s1;
					has_tag_s2 <= 1'b1;
				end
				default: begin
					status_s2  <= wsts_pkg::ST_NONE;
					qused_s2   <= '0;
					has_tag_s2 <= 1'b0;
				end
			endcase
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (cmd.deliver) begin
			status_q     <= status_s2;
			out_tag_q    <= has_tag_s2 ? wsts_pkg::TAG_W'(rdata_q) : '0;
			queue_used_q <= wsts_pkg::QUSED_W'(qused_s2);
		end
	end

	assign status     = status_q;
	assign out_tag    = out_tag_q;
	assign queue_used = queue_used_q;

endmodule

[src/work_stealing_task_scheduler.sv]
// ----------------------------------------------------------------------------
// Work-stealing task scheduler
// Per-worker double-ended task queues with round-robin submit and stealing.
// ----------------------------------------------------------------------------
// Each transaction is taken in a step that chooses its queue; an access step then
// updates the queue pointers and drives the single port of the task memory, and
// the registered read data is loaded into the output register on delivery. A new
// request is taken while a result is delivered, so with the result side ready the
// block overlaps transactions; a stalled output holds the block in delivery. The
// task memory holds NUM_QUEUES x QUEUE_DEPTH tags, is not cleared after reset,
// and is only read at entries that hold queued tasks.
// The active worker count lives at byte address 0 of the register port.
// ----------------------------------------------------------------------------
module work_stealing_task_scheduler #(
	parameter int NUM_QUEUES  = wsts_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = wsts_pkg::QUEUE_DEPTH_DEF,
	parameter int TAG_BITS    = wsts_pkg::TAG_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wsts_pkg::PADDR_W-1:0]  paddr,
	input  logic [wsts_pkg::PDATA_W-1:0]  pwdata,
	output logic [wsts_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	// Request channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [wsts_pkg::TAG_W-1:0]    task_tag,
	input  logic [wsts_pkg::WORKER_W-1:0] worker,
	// Result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wsts_pkg::STATUS_W-1:0] status,
	output logic [wsts_pkg::TAG_W-1:0]    out_tag,
	output logic [wsts_pkg::QUSED_W-1:0]  queue_used
);

	logic [wsts_pkg::ACTIVE_W-1:0] active_workers_q;
	logic                          reg_hit;
	wsts_pkg::cmd_t                cmd;

	// Register decode
	assign reg_hit = (paddr[wsts_pkg::PADDR_W-1:2] == wsts_pkg::REG_ACTIVE_WORKERS);
	assign pready  = 1'b1;

	// Hold the active worker count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_workers_q <= wsts_pkg::ACTIVE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			active_workers_q <= pwdata[wsts_pkg::ACTIVE_W-1:0];
		end
	end

	// Read back
	assign prdata = reg_hit ? wsts_pkg::PDATA_W'(active_workers_q) : '0;

	wsts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	wsts_dp #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_BITS    (TAG_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.active_workers (active_workers_q),
		.command        (command),
		.task_tag       (task_tag),
		.worker         (worker),
		.status         (status),
		.out_tag        (out_tag),
		.queue_used     (queue_used)
	);

endmodule
